/* sv/lsc_pkg.sv */
package lsc_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int COUNT_WIDTH  = 24;

   localparam int GAIN_W  = 16;
   localparam int THR_W   = 23;
   localparam int PAD_W   = 14;
   localparam int APW_W   = 12;
   localparam int FORCE_W = 24;
   localparam int PRESS_W = 32;
   localparam int AREA_W  = 27;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 23;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_THR  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAD  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_APW  = 2'd3;

   localparam int REQ_DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = SAMPLE_WIDTH + FORCE_W + PRESS_W + AREA_W + 1 + COUNT_WIDTH + 2;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int MUL_A_W = SAMPLE_WIDTH + 1;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int FORCE_Q20 = 642690;

   localparam int MAG_W     = FORCE_W;
   localparam int DIV_W     = MAG_W + 9;
   localparam int DIV_STEPS = DIV_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* sv/lsc_mul.sv */
module lsc_mul (
   input  logic                                 clock,
   input  logic signed [lsc_pkg::MUL_A_W-1:0]   op_a,
   input  logic signed [lsc_pkg::MUL_B_W-1:0]   op_b,
   output logic signed [lsc_pkg::PROD_W-1:0]    product
);
   import lsc_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

/* sv/lsc_div.sv */
module lsc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lsc_pkg::DIV_W-1:0]     dividend,
   input  logic [lsc_pkg::PAD_W-1:0]     divisor,
   output logic [lsc_pkg::DIV_W-1:0]     quotient,
   output lsc_pkg::div_stat_type         stat
);
   import lsc_pkg::*;

   logic [PAD_W-1:0]     rem_ff, rem_in;
   logic [PAD_W-1:0]     den_ff, den_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [PAD_W:0]       trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? PAD_W'(trial - {1'b0, den_ff}) : trial[PAD_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* sv/load_ema_contact_step_counter.sv */
// Smooths load-cell weight samples with an exponential moving average and reports force,
// pressure, contact area, contact state and a step count for every sample. Each sample
// passes through the accepting state, five multiply and round steps on one shared
// multiplier, 33 steps of a restoring divider for the pressure, a state to collect the
// quotient and one to load the output register. A finished result waits in the output
// register while the next sample is accepted.
module load_ema_contact_step_counter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // weight_sample
   input  logic [lsc_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // smoothed_weight, force_out, pressure_out, contact_area, in_contact_now,
   // step_total, contact_started, contact_ended, zero padding
   output logic [lsc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [lsc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [lsc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import lsc_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EMA  = 3'd1;
   localparam logic [2:0] S_AVG  = 3'd2;
   localparam logic [2:0] S_FMUL = 3'd3;
   localparam logic [2:0] S_AMUL = 3'd4;
   localparam logic [2:0] S_AREA = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_WB   = 3'd7;

   logic [2:0] state_ff, state_in;

   logic [GAIN_W-1:0] gain_ff;
   logic [THR_W-1:0]  thr_ff;
   logic [PAD_W-1:0]  pad_ff;
   logic [APW_W-1:0]  apw_ff;

   logic signed [SAMPLE_WIDTH-1:0] x_ff, prev_ff, avg_ff, prev, a_in;
   logic                           touch_ff;
   logic [COUNT_WIDTH-1:0]         step_ff;
   logic                           started_ff, ended_ff;
   logic signed [FORCE_W-1:0]      force_ff;
   logic signed [AREA_W-1:0]       area_ff;
   logic [PRESS_W-1:0]             press_ff, press_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic                    out_free;

   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [PROD_W-1:0]  product, rnd16, rnd20, rnd10;

   logic                 above;
   logic                 neg;
   logic [MAG_W-1:0]     mag;
   logic [DIV_W-1:0]     dividend, quotient;
   logic [PAD_W-1:0]     divisor;
   logic                 div_start;
   div_stat_type         div_stat;

   lsc_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   lsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient),
      .stat     (div_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_W'(9830);
         thr_ff  <= THR_W'(512);
         pad_ff  <= PAD_W'(1024);
         apw_ff  <= APW_W'(320);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GAIN: gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_THR:  thr_ff  <= csr_wdata[THR_W-1:0];
            CSR_PAD:  pad_ff  <= csr_wdata[PAD_W-1:0];
            CSR_APW:  apw_ff  <= csr_wdata[APW_W-1:0];
            default: ;
         endcase
      end
   end

   assign prev = (avg_ff == '0) ? x_ff : avg_ff;

   always_comb begin
      case (state_ff)
         S_EMA: begin
            op_a = MUL_A_W'({x_ff[SAMPLE_WIDTH-1], x_ff} - {prev[SAMPLE_WIDTH-1], prev});
            op_b = MUL_B_W'({1'b0, gain_ff});
         end
         S_FMUL: begin
            op_a = {avg_ff[SAMPLE_WIDTH-1], avg_ff};
            op_b = MUL_B_W'(FORCE_Q20);
         end
         default: begin
            op_a = {avg_ff[SAMPLE_WIDTH-1], avg_ff};
            op_b = MUL_B_W'({1'b0, apw_ff});
         end
      endcase
   end

   assign rnd16 = (product + PROD_W'(32768)) >>> 16;
   assign rnd20 = (product + PROD_W'(524288)) >>> 20;
   assign rnd10 = (product + PROD_W'(512)) >>> 10;
   assign a_in  = prev_ff + rnd16[SAMPLE_WIDTH-1:0];

   assign above = $signed({avg_ff[SAMPLE_WIDTH-1], avg_ff}) >=
                  $signed({2'b00, thr_ff});

   assign neg       = force_ff[FORCE_W-1];
   assign mag       = neg ? MAG_W'(-force_ff) : MAG_W'(force_ff);
   assign dividend  = {mag, 9'b0} + DIV_W'({mag, 7'b0});
   assign divisor   = (pad_ff == '0) ? PAD_W'(1) : pad_ff;
   assign div_start = (state_ff == S_AREA);

   always_comb begin
      if (!neg) begin
         press_in = (quotient > DIV_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : quotient[PRESS_W-1:0];
      end else begin
         press_in = (quotient > DIV_W'(32'h8000_0000)) ? 32'h8000_0000 :
                    PRESS_W'(~quotient + 1'b1);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_EMA;
         S_EMA:   state_in = S_AVG;
         S_AVG:   state_in = S_FMUL;
         S_FMUL:  state_in = S_AMUL;
         S_AMUL:  state_in = S_AREA;
         S_AREA:  state_in = S_DIV;
         S_DIV:   if (div_stat.done) state_in = S_WB;
         S_WB:    if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (state_ff == S_WB && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         avg_ff       <= '0;
         touch_ff     <= 1'b0;
         step_ff      <= '0;
         started_ff   <= 1'b0;
         ended_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_AVG) begin
            avg_ff <= a_in;
         end
         if (state_ff == S_FMUL) begin
            started_ff <= !touch_ff && above;
            ended_ff   <= touch_ff && !above;
            touch_ff   <= above;
            if (touch_ff && !above) begin
               step_ff <= step_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         x_ff <= req_tdata[SAMPLE_WIDTH-1:0];
      end
      if (state_ff == S_EMA) begin
         prev_ff <= prev;
      end
      if (state_ff == S_AMUL) begin
         force_ff <= rnd20[FORCE_W-1:0];
      end
      if (state_ff == S_AREA) begin
         area_ff <= AREA_W'(pad_ff) + rnd10[AREA_W-1:0];
      end
      if (state_ff == S_DIV && div_stat.done) begin
         press_ff <= press_in;
      end
      if (state_ff == S_WB && out_free) begin
         rsp_data_ff <= RSP_DATA_W'({ended_ff, started_ff, step_ff, touch_ff, area_ff,
                                     press_ff, force_ff, avg_ff});
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_idle_div_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_stat.busy)
      else $error("divider busy while sequencer idle");

   a_one_event : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(started_ff && ended_ff))
      else $error("contact start and end flagged together");

   a_step_on_end : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(step_ff)) |-> (ended_ff && step_ff == $past(step_ff) + 1'b1))
      else $error("step count moved without a contact end");
`endif

endmodule

/* tb/load_ema_contact_step_counter_tb.sv */
module load_ema_contact_step_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsc_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct {
      logic signed [23:0] smoothed;
      logic signed [23:0] force_val;
      logic signed [31:0] pressure;
      logic signed [26:0] area;
      logic               in_contact;
      logic [23:0]        steps;
      logic               started;
      logic               ended;
   } load_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Register copies and block state as the predictor sees them.
   logic [15:0]        gain_reg = 16'd9830;
   logic [22:0]        threshold_reg = 23'd512;
   logic [13:0]        pad_reg = 14'd1024;
   logic [11:0]        slope_reg = 12'd320;
   logic signed [23:0] smoothed_avg = '0;
   logic               touching = 1'b0;
   logic [23:0]        step_count = '0;

   load_result_type sample_results_q[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           hold_cycles = 0;
   int           stall_left = 0;
   bit           calm_mode = 1'b0;

   load_ema_contact_step_counter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL load_ema_contact_step_counter");
         $finish;
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(0, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [23:0] to_sample(input longint value);
      if (value > 8388607) begin
         return 24'sh7fffff;
      end
      if (value < -8388608) begin
         return 24'sh800000;
      end
      return value[23:0];
   endfunction

   // Smooths one sample and derives force, pressure, area and contact events,
   // updating the predicted block state on the way.
   function automatic load_result_type ema_contact_step(input logic signed [23:0] weight);
      load_result_type r;
      longint       x;
      longint       prev;
      longint       a;
      longint       frc;
      longint       prs;
      longint       area;
      longint       divisor;
      logic         above;
      x = weight;
      prev = (smoothed_avg == 0) ? x : longint'(smoothed_avg);
      a = prev + ((longint'(gain_reg) * (x - prev) + 64'sd32768) >>> 16);
      smoothed_avg = a[23:0];
      a = smoothed_avg;
      frc = (a * 64'sd642690 + 64'sd524288) >>> 20;
      if (frc > 64'sd8388607) begin
         frc = 64'sd8388607;
      end else if (frc < -64'sd8388608) begin
         frc = -64'sd8388608;
      end
      divisor = (pad_reg == 0) ? 64'sd1 : longint'(pad_reg);
      prs = (frc * 64'sd640) / divisor;
      if (prs > 64'sd2147483647) begin
         prs = 64'sd2147483647;
      end else if (prs < -64'sd2147483648) begin
         prs = -64'sd2147483648;
      end
      area = longint'(pad_reg) + ((a * longint'(slope_reg) + 64'sd512) >>> 10);
      if (area > 64'sd67108863) begin
         area = 64'sd67108863;
      end else if (area < -64'sd67108864) begin
         area = -64'sd67108864;
      end
      above = (a >= longint'(threshold_reg));
      r.started = !touching && above;
      r.ended = touching && !above;
      if (r.started) begin
         touching = 1'b1;
      end else if (r.ended) begin
         touching = 1'b0;
         step_count = step_count + 24'd1;
      end
      r.smoothed = smoothed_avg;
      r.force_val = frc[23:0];
      r.pressure = prs[31:0];
      r.area = area[26:0];
      r.in_contact = touching;
      r.steps = step_count;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      load_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sample_results_q.size() == 0) begin
            $error("result transaction with no sample outstanding");
            mismatch_count++;
         end else begin
            want = sample_results_q.pop_front();
            check_field("smoothed_weight", 32'($unsigned(want.smoothed)),
                        32'(rsp_tdata[23:0]));
            check_field("force_out", 32'($unsigned(want.force_val)),
                        32'(rsp_tdata[47:24]));
            check_field("pressure_out", want.pressure, rsp_tdata[79:48]);
            check_field("contact_area", 32'($unsigned(want.area)),
                        32'(rsp_tdata[106:80]));
            check_field("in_contact_now", 32'(want.in_contact), 32'(rsp_tdata[107]));
            check_field("step_total", 32'(want.steps), 32'(rsp_tdata[131:108]));
            check_field("contact_started", 32'(want.started), 32'(rsp_tdata[132]));
            check_field("contact_ended", 32'(want.ended), 32'(rsp_tdata[133]));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm_mode && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
      end
   end

   task automatic send_weight(input logic signed [23:0] weight);
      int gap;
      gap = calm_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= weight;
      do @(posedge clock); while (!req_tready);
      sample_results_q.push_back(ema_contact_step(weight));
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drain();
      while (sample_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Bits above a register's width carry random junk that the block must drop.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index, input logic [22:0] value);
      logic [22:0] word;
      word = 23'($urandom);
      case (index)
         CSR_GAIN: begin
            word[15:0] = value[15:0];
            gain_reg = value[15:0];
         end
         CSR_THR: begin
            word = value;
            threshold_reg = value;
         end
         CSR_PAD: begin
            word[13:0] = value[13:0];
            pad_reg = value[13:0];
         end
         default: begin
            word[11:0] = value[11:0];
            slope_reg = value[11:0];
         end
      endcase
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= word;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [15:0] gain, input logic [22:0] threshold,
                                input logic [13:0] pad, input logic [11:0] slope);
      write_reg(CSR_GAIN, 23'(gain));
      write_reg(CSR_THR, threshold);
      write_reg(CSR_PAD, 23'(pad));
      write_reg(CSR_APW, 23'(slope));
      csr_we <= 1'b0;
   endtask

   // The first sample seeds the average; a dip below the threshold counts a step.
   task automatic test_reset_defaults();
      send_weight(24'sd2000);
      send_weight(24'sd2000);
      send_weight(-24'sd3000);
      send_weight(-24'sd3000);
      send_weight(-24'sd3000);
      send_weight(-24'sd3000);
      send_weight(24'sd0);
      stop_sending();
   endtask

   task automatic test_extremes();
      wait_drain();
      load_settings(16'hffff, 23'h7fffff, 14'd1, 12'hfff);
      send_weight(24'sh7fffff);
      send_weight(24'sh7fffff);
      send_weight(24'sh800000);
      send_weight(24'sh7fffff);
      stop_sending();
      wait_drain();
      // A zero pad area divides as one.
      load_settings(16'd0, 23'd0, 14'd0, 12'd0);
      send_weight(24'sh800000);
      send_weight(24'sd1);
      send_weight(24'sd0);
      stop_sending();
      wait_drain();
      load_settings(16'hffff, 23'd3, 14'h3fff, 12'd320);
      send_weight(24'sd1);
      send_weight(24'sd1);
      stop_sending();
      wait_drain();
      // The average lands exactly on zero, so the next sample seeds it again.
      load_settings(16'h8000, 23'd3, 14'd63, 12'd320);
      send_weight(-24'sd1);
      send_weight(24'sd5000);
      send_weight(24'sd0);
      stop_sending();
   endtask

   task automatic test_random_phases();
      int          phase;
      int          sent;
      int          burst;
      int          k;
      int          spread;
      logic [15:0] gain;
      logic [22:0] threshold;
      logic [13:0] pad;
      logic [11:0] slope;
      for (phase = 0; phase < 8; phase++) begin
         wait_drain();
         case ($urandom_range(0, 5))
            0: gain = 16'd0;
            1: gain = 16'hffff;
            default: gain = 16'($urandom_range(6000, 65535));
         endcase
         case ($urandom_range(0, 5))
            0: threshold = 23'd0;
            1: threshold = 23'h7fffff;
            default: threshold = 23'($urandom_range(0, 300000));
         endcase
         case ($urandom_range(0, 5))
            0: pad = 14'($urandom_range(0, 63));
            1: pad = 14'h3fff;
            default: pad = 14'($urandom_range(64, 16383));
         endcase
         case ($urandom_range(0, 5))
            0: slope = 12'd0;
            1: slope = 12'hfff;
            default: slope = 12'($urandom_range(0, 4095));
         endcase
         load_settings(gain, threshold, pad, slope);
         calm_mode = (phase == 3);
         sent = 0;
         while (sent < 60) begin
            if ($urandom_range(0, 9) < 7) begin
               burst = $urandom_range(1, 6);
               for (k = 0; k < burst; k++) begin
                  spread = $urandom_range(0, 60000);
                  send_weight(to_sample(longint'(threshold) + spread));
               end
               sent += burst;
               burst = $urandom_range(1, 6);
               for (k = 0; k < burst; k++) begin
                  spread = $urandom_range(1, 60000);
                  send_weight(to_sample(longint'(threshold) - spread));
               end
               sent += burst;
            end else begin
               burst = $urandom_range(1, 3);
               for (k = 0; k < burst; k++) begin
                  send_weight(24'($urandom));
               end
               sent += burst;
            end
         end
         stop_sending();
         calm_mode = 1'b0;
      end
   endtask

   // The receiver stops for a long stretch so the block fills and stalls its input.
   task automatic test_output_stall();
      int k;
      int spread;
      wait_drain();
      hold_cycles = 1500;
      for (k = 0; k < 40; k++) begin
         spread = $urandom_range(0, 4000);
         send_weight(to_sample(longint'(threshold_reg) + spread - 2000));
      end
      stop_sending();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extremes();
      test_random_phases();
      test_output_stall();
      wait_drain();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && sample_results_q.size() == 0) begin
         $display("PASS load_ema_contact_step_counter");
      end else begin
         $display("FAIL load_ema_contact_step_counter");
      end
      $finish;
   end

endmodule
